// ===== sv/spts_pkg.sv =====
package spts_pkg;

	localparam int TILE_EDGE   = 64;
	localparam int MAX_WIDTH   = 512;
	localparam int MAX_HEIGHT  = 512;
	localparam int MAX_RESULTS = 64;

	localparam int TILE_SHIFT = $clog2(TILE_EDGE);
	localparam int GRID_X     = (MAX_WIDTH + TILE_EDGE - 1) / TILE_EDGE;
	localparam int GRID_Y     = (MAX_HEIGHT + TILE_EDGE - 1) / TILE_EDGE;
	localparam int NTILES     = GRID_X * GRID_Y;

	localparam int CMD_W        = 3;
	localparam int X_W          = 9;
	localparam int Y_W          = 9;
	localparam int COLOR_W      = 32;
	localparam int CFG_W        = 10;
	localparam int CFG_IDX_W    = 1;
	localparam int TILE_COORD_W = 3;
	localparam int ALPHA_LSB    = 24;

	localparam int TX_W   = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int TY_W   = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int NTX_W  = $clog2(GRID_X + 1);
	localparam int NTY_W  = $clog2(GRID_Y + 1);
	localparam int TI_W   = (NTILES > 1) ? $clog2(NTILES) : 1;
	localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(PIX_DEPTH);
	localparam int RES_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 2;
	localparam int OP_W        = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int OC_W        = $clog2(OUT_DEPTH + 1);

	localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(512);
	localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(512);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_READ        = 3'd0,
		CMD_WRITE       = 3'd1,
		CMD_CLEAR       = 3'd2,
		CMD_CLEAR_DIRTY = 3'd3,
		CMD_COLLECT     = 3'd4
	} cmd_code_t;

	typedef enum logic [2:0] {
		OP_READ,
		OP_WRITE,
		OP_CLEAR_FREE,
		OP_CLEAR_FILL,
		OP_CLEAR_DIRTY,
		OP_COLLECT
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               in_img;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [COLOR_W-1:0] color;
		logic [TX_W-1:0]    tx;
		logic [TY_W-1:0]    ty;
		logic [NTX_W-1:0]   ntx;
		logic [NTY_W-1:0]   nty;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0]      pixel;
		logic                    in_range;
		logic                    allocated;
		logic                    dirty;
		logic [TILE_COORD_W-1:0] tile_x;
		logic [TILE_COORD_W-1:0] tile_y;
		logic                    last;
	} result_t;

	function automatic logic [TI_W-1:0] tile_index(input logic [TX_W-1:0] tx,
			input logic [TY_W-1:0] ty);
		return TI_W'(int'(ty) * GRID_X + int'(tx));
	endfunction

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
	endfunction

	function automatic logic [X_W-1:0] clip_x(input logic [X_W:0] e);
		logic [X_W:0] m;
		m = (e > (X_W + 1)'(MAX_WIDTH)) ? (X_W + 1)'(MAX_WIDTH) : e;
		return X_W'(m - (X_W + 1)'(1));
	endfunction

	function automatic logic [Y_W-1:0] clip_y(input logic [Y_W:0] e);
		logic [Y_W:0] m;
		m = (e > (Y_W + 1)'(MAX_HEIGHT)) ? (Y_W + 1)'(MAX_HEIGHT) : e;
		return Y_W'(m - (Y_W + 1)'(1));
	endfunction

endpackage

// ===== sv/spts_ram.sv =====
module spts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/spts_front.sv =====
module spts_front (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spts_pkg::CMD_W-1:0]    cmd,
	input  logic [spts_pkg::X_W-1:0]      pixel_x,
	input  logic [spts_pkg::Y_W-1:0]      pixel_y,
	input  logic [spts_pkg::COLOR_W-1:0]  color_in,
	input  logic [spts_pkg::CFG_W-1:0]    image_width,
	input  logic [spts_pkg::CFG_W-1:0]    image_height,
	input  logic                          q_full,
	output logic                          q_push,
	output spts_pkg::cmd_t                q_word
);

	import spts_pkg::*;

	logic [CFG_W-1:0] eff_w;
	logic [CFG_W-1:0] eff_h;
	logic [CFG_W:0]   w_round;
	logic [CFG_W:0]   h_round;
	logic             in_img;
	logic             keep;
	op_t              op;

	assign eff_w = (image_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : image_width;
	assign eff_h = (image_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : image_height;
	assign w_round = {1'b0, eff_w} + (CFG_W + 1)'(TILE_EDGE - 1);
	assign h_round = {1'b0, eff_h} + (CFG_W + 1)'(TILE_EDGE - 1);
	assign in_img = (CFG_W'(pixel_x) < eff_w) && (CFG_W'(pixel_y) < eff_h);

	always_comb begin
		op   = OP_READ;
		keep = 1'b0;
		unique case (cmd)
			CMD_READ: begin
				op   = OP_READ;
				keep = 1'b1;
			end
			CMD_WRITE: begin
				op   = OP_WRITE;
				keep = in_img;
			end
			CMD_CLEAR: begin
				op   = (color_in[COLOR_W-1:ALPHA_LSB] == '0) ? OP_CLEAR_FREE : OP_CLEAR_FILL;
				keep = 1'b1;
			end
			CMD_CLEAR_DIRTY: begin
				op   = OP_CLEAR_DIRTY;
				keep = 1'b1;
			end
			CMD_COLLECT: begin
				op   = OP_COLLECT;
				keep = 1'b1;
			end
			default: begin
				op   = OP_READ;
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

	always_comb begin
		q_word.op     = op;
		q_word.in_img = in_img;
		q_word.x      = pixel_x;
		q_word.y      = pixel_y;
		q_word.color  = color_in;
		q_word.tx     = TX_W'(pixel_x >> TILE_SHIFT);
		q_word.ty     = TY_W'(pixel_y >> TILE_SHIFT);
		q_word.ntx    = NTX_W'(w_round >> TILE_SHIFT);
		q_word.nty    = NTY_W'(h_round >> TILE_SHIFT);
	end

endmodule

// ===== sv/spts_cmd_queue.sv =====
module spts_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spts_pkg::cmd_t push_word,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output spts_pkg::cmd_t head
);

	import spts_pkg::*;

	cmd_t            entries_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wptr_q;
	logic [QP_W-1:0] rptr_q;
	logic [QC_W-1:0] cnt_q;

	assign full  = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entries_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QP_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QP_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QC_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_word;
		end
	end

endmodule

// ===== sv/spts_back.sv =====
module spts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  spts_pkg::cmd_t  q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output spts_pkg::result_t out_word
);

	import spts_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FILL  = 5'b00010,
		ST_WPIX  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t              state_q;
	logic [NTILES-1:0]   alloc_q;
	logic [NTILES-1:0]   dirty_q;

	logic                rd_valid_s1;
	logic                rd_alloc_s1;
	logic                rd_dirty_s1;
	logic                rd_inside_s1;

	logic [X_W-1:0]      fx_q;
	logic [X_W-1:0]      fx0_q;
	logic [X_W-1:0]      fx1_q;
	logic [Y_W-1:0]      fy_q;
	logic [Y_W-1:0]      fy1_q;
	logic [COLOR_W-1:0]  fcolor_q;
	logic                fill_write_q;
	logic [X_W-1:0]      wx_q;
	logic [Y_W-1:0]      wy_q;
	logic [COLOR_W-1:0]  wcolor_q;
	logic [TI_W-1:0]     wtile_q;

	logic [TX_W-1:0]     si_q;
	logic [TY_W-1:0]     sj_q;
	logic [NTX_W-1:0]    sntx_q;
	logic [NTY_W-1:0]    snty_q;
	logic                pend_v_q;
	logic [TX_W-1:0]     pend_x_q;
	logic [TY_W-1:0]     pend_y_q;
	logic [RES_W-1:0]    nrep_q;

	result_t             ofifo_q [OUT_DEPTH];
	logic [OP_W-1:0]     owr_q;
	logic [OP_W-1:0]     ord_q;
	logic [OC_W-1:0]     ocnt_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [COLOR_W-1:0]  ram_wdata;
	logic [COLOR_W-1:0]  ram_rdata;

	logic [TI_W-1:0]     head_ti;
	logic                head_alloc;
	logic [NTILES-1:0]   clear_mask;
	logic                grid_empty;
	logic [X_W:0]        tile_x_base;
	logic [Y_W:0]        tile_y_base;
	logic [X_W:0]        grid_x_end;
	logic [Y_W:0]        grid_y_end;
	logic                fill_done;

	logic                out_pop;
	logic [OC_W:0]       occ;
	logic                occ_ok;
	logic                can_push;
	logic [TI_W-1:0]     scan_ti;
	logic                hit;
	logic                scan_stop;
	logic                scan_end;
	logic                col_push;
	logic                col_last;
	logic                push;
	result_t             push_word;

	spts_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PIX_DEPTH)
	) u_pixels (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign head_ti    = tile_index(q_head.tx, q_head.ty);
	assign head_alloc = alloc_q[head_ti];
	assign grid_empty = (q_head.ntx == '0) || (q_head.nty == '0);
	assign tile_x_base = (X_W + 1)'(q_head.tx) << TILE_SHIFT;
	assign tile_y_base = (Y_W + 1)'(q_head.ty) << TILE_SHIFT;
	assign grid_x_end  = (X_W + 1)'(q_head.ntx) << TILE_SHIFT;
	assign grid_y_end  = (Y_W + 1)'(q_head.nty) << TILE_SHIFT;
	assign fill_done   = (fx_q == fx1_q) && (fy_q == fy1_q);

	always_comb begin
		for (int j = 0; j < GRID_Y; j++) begin
			for (int i = 0; i < GRID_X; i++) begin
				clear_mask[j * GRID_X + i] = (i < int'(q_head.ntx)) && (j < int'(q_head.nty));
			end
		end
	end

	assign out_pop  = (ocnt_q != '0) && !out_stall;
	assign occ      = {1'b0, ocnt_q} + (OC_W + 1)'(rd_valid_s1) - (OC_W + 1)'(out_pop);
	assign occ_ok   = occ < (OC_W + 1)'(OUT_DEPTH);
	assign can_push = occ_ok && !rd_valid_s1;

	assign scan_ti   = tile_index(si_q, sj_q);
	assign hit       = alloc_q[scan_ti] && dirty_q[scan_ti];
	assign scan_stop = pend_v_q && (nrep_q == RES_W'(MAX_RESULTS - 1));
	assign scan_end  = (NTX_W'(si_q) == sntx_q - NTX_W'(1)) &&
		(NTY_W'(sj_q) == snty_q - NTY_W'(1));

	always_comb begin
		col_push = 1'b0;
		col_last = 1'b1;
		if (state_q == ST_SCAN && can_push) begin
			col_push = scan_stop || (hit && pend_v_q);
			col_last = scan_stop;
		end else if (state_q == ST_FLUSH && can_push) begin
			col_push = pend_v_q;
		end
	end

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && !q_empty) begin
			q_pop = (q_head.op == OP_READ) ? occ_ok : 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pix_addr(q_head.x, q_head.y);
		ram_wdata = q_head.color;
		unique case (state_q)
			ST_IDLE: begin
				ram_we = q_pop && (q_head.op == OP_WRITE) && head_alloc;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_addr  = pix_addr(fx_q, fy_q);
				ram_wdata = fcolor_q;
			end
			ST_WPIX: begin
				ram_we    = 1'b1;
				ram_addr  = pix_addr(wx_q, wy_q);
				ram_wdata = wcolor_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			alloc_q     <= '0;
			dirty_q     <= '0;
			rd_valid_s1 <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= q_pop && (q_head.op == OP_READ);
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_head.op)
							OP_WRITE: begin
								if (head_alloc) begin
									dirty_q[head_ti] <= 1'b1;
								end else begin
									state_q <= ST_FILL;
								end
							end
							OP_CLEAR_FREE: begin
								alloc_q <= '0;
								dirty_q <= '0;
							end
							OP_CLEAR_FILL: begin
								alloc_q <= alloc_q | clear_mask;
								dirty_q <= dirty_q | clear_mask;
								if (!grid_empty) begin
									state_q <= ST_FILL;
								end
							end
							OP_CLEAR_DIRTY: begin
								dirty_q <= '0;
							end
							OP_COLLECT: begin
								pend_v_q <= 1'b0;
								if (!grid_empty) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					if (fill_done) begin
						state_q <= fill_write_q ? ST_WPIX : ST_IDLE;
					end
				end
				ST_WPIX: begin
					alloc_q[wtile_q] <= 1'b1;
					dirty_q[wtile_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_SCAN: begin
					if (can_push) begin
						if (scan_stop) begin
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							if (hit) begin
								pend_v_q <= 1'b1;
							end
							if (scan_end) begin
								state_q <= ST_FLUSH;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == OP_READ) begin
			rd_inside_s1 <= q_head.in_img;
			rd_alloc_s1  <= q_head.in_img && head_alloc;
			rd_dirty_s1  <= q_head.in_img && head_alloc && dirty_q[head_ti];
		end
		if (q_pop && q_head.op == OP_WRITE && !head_alloc) begin
			fx_q         <= X_W'(tile_x_base);
			fx0_q        <= X_W'(tile_x_base);
			fx1_q        <= clip_x(tile_x_base + (X_W + 1)'(TILE_EDGE));
			fy_q         <= Y_W'(tile_y_base);
			fy1_q        <= clip_y(tile_y_base + (Y_W + 1)'(TILE_EDGE));
			fcolor_q     <= '0;
			fill_write_q <= 1'b1;
			wx_q         <= q_head.x;
			wy_q         <= q_head.y;
			wcolor_q     <= q_head.color;
			wtile_q      <= head_ti;
		end else if (q_pop && q_head.op == OP_CLEAR_FILL) begin
			fx_q         <= '0;
			fx0_q        <= '0;
			fx1_q        <= clip_x(grid_x_end);
			fy_q         <= '0;
			fy1_q        <= clip_y(grid_y_end);
			fcolor_q     <= q_head.color;
			fill_write_q <= 1'b0;
		end else if (state_q == ST_FILL) begin
			if (fx_q == fx1_q) begin
				fx_q <= fx0_q;
				fy_q <= fy_q + Y_W'(1);
			end else begin
				fx_q <= fx_q + X_W'(1);
			end
		end
		if (q_pop && q_head.op == OP_COLLECT) begin
			si_q   <= '0;
			sj_q   <= '0;
			sntx_q <= q_head.ntx;
			snty_q <= q_head.nty;
			nrep_q <= '0;
		end else if (state_q == ST_SCAN && can_push && !scan_stop) begin
			if (hit) begin
				pend_x_q <= si_q;
				pend_y_q <= sj_q;
				if (pend_v_q) begin
					nrep_q <= nrep_q + RES_W'(1);
				end
			end
			if (NTX_W'(si_q) == sntx_q - NTX_W'(1)) begin
				si_q <= '0;
				sj_q <= sj_q + TY_W'(1);
			end else begin
				si_q <= si_q + TX_W'(1);
			end
		end
	end

	assign push = rd_valid_s1 || col_push;

	always_comb begin
		if (rd_valid_s1) begin
			push_word.pixel     = rd_alloc_s1 ? ram_rdata : '0;
			push_word.in_range  = rd_inside_s1;
			push_word.allocated = rd_alloc_s1;
			push_word.dirty     = rd_dirty_s1;
			push_word.tile_x    = '0;
			push_word.tile_y    = '0;
			push_word.last      = 1'b1;
		end else begin
			push_word.pixel     = '0;
			push_word.in_range  = 1'b0;
			push_word.allocated = 1'b0;
			push_word.dirty     = 1'b0;
			push_word.tile_x    = TILE_COORD_W'(pend_x_q);
			push_word.tile_y    = TILE_COORD_W'(pend_y_q);
			push_word.last      = col_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (push) begin
				owr_q <= (owr_q == OP_W'(OUT_DEPTH - 1)) ? '0 : owr_q + OP_W'(1);
			end
			if (out_pop) begin
				ord_q <= (ord_q == OP_W'(OUT_DEPTH - 1)) ? '0 : ord_q + OP_W'(1);
			end
			if (push && !out_pop) begin
				ocnt_q <= ocnt_q + OC_W'(1);
			end else if (out_pop && !push) begin
				ocnt_q <= ocnt_q - OC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ofifo_q[owr_q] <= push_word;
		end
	end

	assign out_valid = (ocnt_q != '0);
	assign out_word  = ofifo_q[ord_q];

endmodule

// ===== sv/sparse_tiled_pixel_store.sv =====
// A 512 x 512 RGBA surface held in one single-port memory and cut into 64 x 64 tiles, each
// with an allocated and a dirty bit; words are taken in order through a two-word command
// queue. A read, or a write to an allocated tile, makes a single access to the pixel memory
// port. A read's data is registered by the memory and then written into the output buffer,
// from which the result is presented. The first write to an unallocated tile zero-fills the
// tile one pixel per cycle before storing the pixel, and an opaque clear writes every pixel
// of the tiles covering the image. A transparent clear and a clear of the dirty marks change
// only the tile bits. Collect looks at the tiles covering the image, one tile per cycle while
// the output buffer can take a report.
// The pixel memory is not cleared after reset; a tile is always filled before it is read.
module sparse_tiled_pixel_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [spts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spts_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [spts_pkg::CMD_W-1:0]          cmd,
	input  logic [spts_pkg::X_W-1:0]            pixel_x,
	input  logic [spts_pkg::Y_W-1:0]            pixel_y,
	input  logic [spts_pkg::COLOR_W-1:0]        color_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [spts_pkg::COLOR_W-1:0]        pixel_out,
	output logic                                in_range,
	output logic                                tile_allocated,
	output logic                                tile_dirty,
	output logic [spts_pkg::TILE_COORD_W-1:0]   dirty_tile_x,
	output logic [spts_pkg::TILE_COORD_W-1:0]   dirty_tile_y,
	output logic                                last
);

	import spts_pkg::*;

	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	cmd_t             q_word;
	cmd_t             q_head;
	result_t          out_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RESET_WIDTH;
			image_height_q <= RESET_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	spts_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color_in    (color_in),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_word      (q_word)
	);

	spts_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_word(q_word),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	spts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	assign pixel_out      = out_word.pixel;
	assign in_range       = out_word.in_range;
	assign tile_allocated = out_word.allocated;
	assign tile_dirty     = out_word.dirty;
	assign dirty_tile_x   = out_word.tile_x;
	assign dirty_tile_y   = out_word.tile_y;
	assign last           = out_word.last;

endmodule

// ===== sv/spts_checker.sv =====
module spts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [spts_pkg::COLOR_W-1:0]      pixel_out,
	input logic                              in_range,
	input logic                              tile_allocated,
	input logic                              tile_dirty,
	input logic                              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out) && $stable(last))
		else $error("result word changed while stalled");

	a_unalloc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tile_allocated |-> pixel_out == '0 && !tile_dirty)
		else $error("unallocated read returned data");

	a_alloc_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tile_allocated |-> in_range && last)
		else $error("allocated bit outside the image or on a tile report");

	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_range && !tile_allocated && pixel_out == '0)
		else $error("tile report carries read fields");

endmodule

bind sparse_tiled_pixel_store spts_checker u_spts_checker (.*);
